/* rtl/hpws_pkg.sv */
// Package for the hit pattern window statistics block.
// Holds the register indexes, channel widths and the per-word statistics type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hpws_pkg;

	localparam int CHAN_W = 7;   // channel number width, 128 channels at most
	localparam int BPOS_W = 4;   // word position within a pattern
	localparam int BSUM_W = 10;  // sum of up to eight channel numbers

	// Configuration register indexes.
	localparam logic CFG_WINDOW_START = 1'b0;
	localparam logic CFG_WINDOW_END   = 1'b1;

	localparam logic [CHAN_W-1:0] WINDOW_END_RESET = 7'h7f;

	// Statistics of one pattern word after windowing.
	typedef struct packed {
		logic [3:0]        hits;      // 0 to 8 hit channels
		logic [2:0]        starts;    // 0 to 4 cluster starts
		logic [BSUM_W-1:0] chan_sum;  // sum of hit channel numbers
		logic              last_hit;  // windowed hit of the highest channel
	} word_stats_t;

endpackage

`default_nettype wire

/* rtl/hpws_word_stats.sv */
// Combinational statistics of one pattern word inside the channel window.
// Depends on hpws_pkg for widths and the word_stats_t type.
`timescale 1ns / 1ps
`default_nettype none

module hpws_word_stats (
	input  wire logic [7:0]                  pattern_word,
	input  wire logic [hpws_pkg::BPOS_W-1:0] word_pos,
	input  wire logic [hpws_pkg::CHAN_W-1:0] window_start,
	input  wire logic [hpws_pkg::CHAN_W-1:0] window_end,
	input  wire logic                        prev_hit,
	output hpws_pkg::word_stats_t            stats
);
	import hpws_pkg::*;

	always_comb begin
		logic [CHAN_W-1:0] ch;
		logic              hit;
		logic              prev;
		stats = '0;
		prev  = prev_hit;
		// Bit 7 carries the lowest channel of the word.
		for (int b = 0; b < 8; b++) begin
			ch  = {word_pos, 3'(b)};
			hit = pattern_word[7-b] && (ch >= window_start) && (ch <= window_end);
			if (hit) begin
				stats.hits     = stats.hits + 4'd1;
				stats.chan_sum = stats.chan_sum + BSUM_W'(ch);
				if (!prev) begin
					stats.starts = stats.starts + 3'd1;
				end
			end
			prev = hit;
		end
		stats.last_hit = prev;
	end

endmodule

`default_nettype wire

/* rtl/hit_pattern_window_stats_top.sv */
// Hit pattern window statistics: one input register, the accumulate step, one result register.
// A last word waits in the input register until the result register can take its result.
// Throughput: one word per cycle; the accumulate step and result register pass a word
// each cycle while the result register is free or being taken.
// Reset: arst_n clears the totals, the handshake state and sets the window to 0..127.
// Depends on hpws_pkg and hpws_word_stats.
`timescale 1ns / 1ps
`default_nettype none

module hit_pattern_window_stats_top #(
	parameter int PATTERN_BYTES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  pattern_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       hit_count,
	output logic [6:0]       cluster_count,
	output logic [12:0]      position_sum,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data
);
	import hpws_pkg::*;

	logic [CHAN_W-1:0] window_start_q, window_end_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [BPOS_W-1:0] byte_pos_q;
	logic              pattern_full_q;
	logic              prev_hit_q;
	logic [7:0]        hit_total_q;
	logic [6:0]        cluster_total_q;
	logic [12:0]       position_total_q;

	logic              out_valid_q;
	logic [7:0]        hit_count_q;
	logic [6:0]        cluster_count_q;
	logic [12:0]       position_sum_q;

	word_stats_t stats;
	logic        advance;
	logic        fire_s1;
	logic        at_end;
	logic [7:0]  hit_next;
	logic [6:0]  cluster_next;
	logic [12:0] position_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q <= '0;
			window_end_q   <= WINDOW_END_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_WINDOW_START) begin
				window_start_q <= cfg_data;
			end else begin
				window_end_q <= cfg_data;
			end
		end
	end

	hpws_word_stats u_word_stats (
		.pattern_word (byte_s1),
		.word_pos     (byte_pos_q),
		.window_start (window_start_q),
		.window_end   (window_end_q),
		.prev_hit     (prev_hit_q),
		.stats        (stats)
	);

	// A word that closes a pattern needs the result register free or being taken.
	assign advance  = !last_s1 || !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign at_end   = ({1'b0, byte_pos_q} + 5'd1) >= 5'(PATTERN_BYTES);

	always_comb begin
		hit_next      = hit_total_q;
		cluster_next  = cluster_total_q;
		position_next = position_total_q;
		if (!pattern_full_q) begin
			hit_next      = hit_total_q + 8'(stats.hits);
			cluster_next  = cluster_total_q + 7'(stats.starts);
			position_next = position_total_q + 13'(stats.chan_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= pattern_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q       <= '0;
			pattern_full_q   <= 1'b0;
			prev_hit_q       <= 1'b0;
			hit_total_q      <= '0;
			cluster_total_q  <= '0;
			position_total_q <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				byte_pos_q       <= '0;
				pattern_full_q   <= 1'b0;
				prev_hit_q       <= 1'b0;
				hit_total_q      <= '0;
				cluster_total_q  <= '0;
				position_total_q <= '0;
			end else if (!pattern_full_q) begin
				hit_total_q      <= hit_next;
				cluster_total_q  <= cluster_next;
				position_total_q <= position_next;
				prev_hit_q       <= stats.last_hit;
				if (at_end) begin
					pattern_full_q <= 1'b1;
				end else begin
					byte_pos_q <= byte_pos_q + BPOS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			hit_count_q     <= hit_next;
			cluster_count_q <= cluster_next;
			position_sum_q  <= position_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit_count     = hit_count_q;
	assign cluster_count = cluster_count_q;
	assign position_sum  = position_sum_q;

	// Every cluster holds at least one hit.
	a_clusters_le_hits: assert property (@(posedge clk) disable iff (!arst_n)
		cluster_total_q <= hit_total_q)
		else $error("cluster total exceeds hit total");

	// The pattern is only marked full on its final word position.
	a_full_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		pattern_full_q |-> (byte_pos_q == BPOS_W'(PATTERN_BYTES - 1)))
		else $error("pattern full before its final word");

	// Closing a pattern clears the totals and raises a result.
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> (out_valid_q && hit_total_q == '0 && byte_pos_q == '0
			&& !pattern_full_q && !prev_hit_q))
		else $error("totals not cleared after the last word");

	// A held result must not be overwritten by the next pattern.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(fire_s1 && last_s1))
		else $error("result register overwritten while held");

endmodule

`default_nettype wire
